>>> design/escape_time_fractal_unit_assert.svh
// Assertion helpers for the escape-time unit; clocked on clk, off while arst_n is low.
`ifndef ESCAPE_TIME_FRACTAL_UNIT_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ETF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ETF_ASSERT_SAME(label, ante, cons, msg)
`define ETF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/etf_pkg.sv
package etf_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS = 28;
	localparam int COUNT_WIDTH = 10;

	localparam int CFG_ADDR_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = COORD_WIDTH;
	localparam int IN_TDATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_WIDTH = ((COUNT_WIDTH + 1 + 7) / 8) * 8;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [2*COORD_WIDTH-1:0] prod_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam coord_t FX_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t FX_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// 4.0, or the largest value when 4.0 does not fit the format
	localparam coord_t THRESHOLD = (FRAC_BITS + 2 < COORD_WIDTH - 1) ?
		coord_t'(longint'(4) << FRAC_BITS) : FX_MAX;

	localparam coord_t JULIA_C_REAL_RST = coord_t'(longint'(-187904819));
	localparam coord_t JULIA_C_IMAG_RST = coord_t'(longint'(72477573));
	localparam count_t MAX_ITER_RST = count_t'(100);

	typedef enum logic [CFG_ADDR_WIDTH-1:0] {
		REG_JULIA_MODE     = 2'd0,
		REG_JULIA_C_REAL   = 2'd1,
		REG_JULIA_C_IMAG   = 2'd2,
		REG_MAX_ITERATIONS = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic escape;
		logic last;
		logic zero_limit;
	} status_t;

endpackage

>>> design/etf_ctrl.sv
module etf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             m_tready,
	input  etf_pkg::status_t sts,
	output logic             s_tready,
	output logic             m_tvalid,
	output etf_pkg::cmd_t    cmd
);

	etf_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			etf_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_nxt = sts.zero_limit ? etf_pkg::ST_DONE : etf_pkg::ST_MUL;
			end
			etf_pkg::ST_MUL: begin
				state_nxt = etf_pkg::ST_UPD;
			end
			etf_pkg::ST_UPD: begin
				if (sts.escape || sts.last)
					state_nxt = etf_pkg::ST_DONE;
				else
					state_nxt = etf_pkg::ST_MUL;
			end
			etf_pkg::ST_DONE: begin
				if (out_free)
					state_nxt = etf_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = etf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			etf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			etf_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
			end
			etf_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
			end
			etf_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= etf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> design/etf_datapath.sv
module etf_datapath (
	input  logic             clk,
	input  etf_pkg::cmd_t    cmd,
	input  etf_pkg::coord_t  point_real,
	input  etf_pkg::coord_t  point_imag,
	input  logic             julia_mode,
	input  etf_pkg::coord_t  julia_c_real,
	input  etf_pkg::coord_t  julia_c_imag,
	input  etf_pkg::count_t  max_iterations,
	output etf_pkg::status_t sts,
	output etf_pkg::count_t  escape_count,
	output logic             escaped
);

	// floor(p / 2^sh) clamped to the coordinate range
	function automatic etf_pkg::coord_t sat_shift(input etf_pkg::prod_t p, input int sh);
		etf_pkg::prod_t s;
		s = p >>> sh;
		if (s > etf_pkg::prod_t'(etf_pkg::FX_MAX))
			return etf_pkg::FX_MAX;
		else if (s < etf_pkg::prod_t'(etf_pkg::FX_MIN))
			return etf_pkg::FX_MIN;
		else
			return etf_pkg::coord_t'(s);
	endfunction

	function automatic etf_pkg::coord_t sat_add(input etf_pkg::coord_t a,
		input etf_pkg::coord_t b);
		logic signed [etf_pkg::COORD_WIDTH:0] s;
		s = {a[etf_pkg::COORD_WIDTH-1], a} + {b[etf_pkg::COORD_WIDTH-1], b};
		if (s[etf_pkg::COORD_WIDTH] != s[etf_pkg::COORD_WIDTH-1])
			return s[etf_pkg::COORD_WIDTH] ? etf_pkg::FX_MIN : etf_pkg::FX_MAX;
		else
			return etf_pkg::coord_t'(s);
	endfunction

	function automatic etf_pkg::coord_t sat_sub(input etf_pkg::coord_t a,
		input etf_pkg::coord_t b);
		logic signed [etf_pkg::COORD_WIDTH:0] s;
		s = {a[etf_pkg::COORD_WIDTH-1], a} - {b[etf_pkg::COORD_WIDTH-1], b};
		if (s[etf_pkg::COORD_WIDTH] != s[etf_pkg::COORD_WIDTH-1])
			return s[etf_pkg::COORD_WIDTH] ? etf_pkg::FX_MIN : etf_pkg::FX_MAX;
		else
			return etf_pkg::coord_t'(s);
	endfunction

	etf_pkg::coord_t zr_q, zi_q, cr_q, ci_q;
	etf_pkg::count_t iter_q;
	logic            esc_q;
	etf_pkg::prod_t  prr_s1, pii_s1, pri_s1;
	etf_pkg::count_t escape_count_q;
	logic            escaped_q;

	etf_pkg::coord_t r2, i2, ri2, mag, nr, ni;

	always_comb begin
		r2  = sat_shift(prr_s1, etf_pkg::FRAC_BITS);
		i2  = sat_shift(pii_s1, etf_pkg::FRAC_BITS);
		ri2 = sat_shift(pri_s1, etf_pkg::FRAC_BITS - 1);
		mag = sat_add(r2, i2);
		nr  = sat_add(sat_sub(r2, i2), cr_q);
		ni  = sat_add(ri2, ci_q);
	end

	assign sts.escape = mag > etf_pkg::THRESHOLD;
	assign sts.last = etf_pkg::count_t'(iter_q + etf_pkg::count_t'(1)) == max_iterations;
	assign sts.zero_limit = max_iterations == '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (julia_mode) begin
				zr_q <= point_real;
				zi_q <= point_imag;
				cr_q <= julia_c_real;
				ci_q <= julia_c_imag;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= point_real;
				ci_q <= point_imag;
			end
			iter_q <= '0;
			esc_q <= 1'b0;
		end
		if (cmd.mul) begin
			prr_s1 <= zr_q * zr_q;
			pii_s1 <= zi_q * zi_q;
			pri_s1 <= zr_q * zi_q;
		end
		if (cmd.upd) begin
			if (sts.escape) begin
				esc_q <= 1'b1;
			end else begin
				zr_q <= nr;
				zi_q <= ni;
				iter_q <= etf_pkg::count_t'(iter_q + etf_pkg::count_t'(1));
			end
		end
		if (cmd.out_load) begin
			escape_count_q <= iter_q;
			escaped_q <= esc_q;
		end
	end

	assign escape_count = escape_count_q;
	assign escaped = escaped_q;

endmodule

>>> design/escape_time_fractal_unit.sv
// Escape-time unit for Mandelbrot and Julia points in signed Q4.28.
// Input stream s_*: one word is one point (real, imaginary). Output stream
// m_*: one word per point, the escape count and an escaped flag.
// Configuration: cfg_we/cfg_addr/cfg_wdata set mode, Julia constant and the
// iteration limit; write them only while no point is in flight.
// One point is worked on at a time. Each iteration test has two steps:
// the three 32x32 products are registered, then scaled, saturated, tested
// against |z|^2 > 4 and z updated unless it escaped. Iteration stops at
// an escape or at the limit; a zero limit skips it and goes straight to
// the output register. A new point is taken only once the last result
// has been loaded into the output register.
// The output register lets the next point be taken and iterated while the
// previous result waits; a finished point then holds until m_tready frees
// the register. Reset clears the handshake state, drops m_tvalid and loads
// the registers with Mandelbrot mode, c = -0.7 + 0.27i and a limit of 100.
`include "escape_time_fractal_unit_assert.svh"

module escape_time_fractal_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// point_real, point_imag
	input  logic [etf_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// escape_count, escaped, zero fill
	output logic [etf_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
	input  logic                                cfg_we,
	input  logic [etf_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
	input  logic [etf_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

	logic            julia_mode_q;
	etf_pkg::coord_t julia_c_real_q;
	etf_pkg::coord_t julia_c_imag_q;
	etf_pkg::count_t max_iterations_q;

	etf_pkg::cmd_t    cmd;
	etf_pkg::status_t sts;
	etf_pkg::coord_t  point_real, point_imag;
	etf_pkg::count_t  escape_count;
	logic             escaped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia_mode_q <= 1'b0;
			julia_c_real_q <= etf_pkg::JULIA_C_REAL_RST;
			julia_c_imag_q <= etf_pkg::JULIA_C_IMAG_RST;
			max_iterations_q <= etf_pkg::MAX_ITER_RST;
		end else if (cfg_we) begin
			case (etf_pkg::cfg_reg_t'(cfg_addr))
				etf_pkg::REG_JULIA_MODE: begin
					julia_mode_q <= cfg_wdata[0];
				end
				etf_pkg::REG_JULIA_C_REAL: begin
					julia_c_real_q <= etf_pkg::coord_t'(cfg_wdata[etf_pkg::COORD_WIDTH-1:0]);
				end
				etf_pkg::REG_JULIA_C_IMAG: begin
					julia_c_imag_q <= etf_pkg::coord_t'(cfg_wdata[etf_pkg::COORD_WIDTH-1:0]);
				end
				etf_pkg::REG_MAX_ITERATIONS: begin
					max_iterations_q <= cfg_wdata[etf_pkg::COUNT_WIDTH-1:0];
				end
				default: begin
					julia_mode_q <= julia_mode_q;
				end
			endcase
		end
	end

	assign point_real = etf_pkg::coord_t'(s_tdata[etf_pkg::COORD_WIDTH-1:0]);
	assign point_imag = etf_pkg::coord_t'(s_tdata[2*etf_pkg::COORD_WIDTH-1:etf_pkg::COORD_WIDTH]);

	etf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	etf_datapath u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.point_real     (point_real),
		.point_imag     (point_imag),
		.julia_mode     (julia_mode_q),
		.julia_c_real   (julia_c_real_q),
		.julia_c_imag   (julia_c_imag_q),
		.max_iterations (max_iterations_q),
		.sts            (sts),
		.escape_count   (escape_count),
		.escaped        (escaped)
	);

	always_comb begin
		m_tdata = '0;
		m_tdata[etf_pkg::COUNT_WIDTH-1:0] = escape_count;
		m_tdata[etf_pkg::COUNT_WIDTH] = escaped;
	end

	`ETF_ASSERT_SAME(a_escaped_below_limit, m_tvalid && escaped, escape_count < max_iterations_q, "escaped word with count at or above the limit")
	`ETF_ASSERT_SAME(a_held_at_limit, m_tvalid && !escaped, escape_count == max_iterations_q, "non-escaped word with count other than the limit")
	`ETF_ASSERT_NEXT(a_one_point_in_flight, s_tvalid && s_tready, !s_tready, "second point taken while one is in flight")

endmodule
